// ===== hdl/mmp_pkg.sv =====
// shared types and codes for the midi message parser
package mmp_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned ClassW = 3;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_D1OF3 = 3'd1;
  localparam logic [PhaseW-1:0] PH_D2OF3 = 3'd2;
  localparam logic [PhaseW-1:0] PH_D1OF2 = 3'd3;
  localparam logic [PhaseW-1:0] PH_SYSEX = 3'd4;
  localparam logic [PhaseW-1:0] PH_DROP  = 3'd5;

  localparam logic [ClassW-1:0] MC_OFF  = 3'd0;
  localparam logic [ClassW-1:0] MC_ON   = 3'd1;
  localparam logic [ClassW-1:0] MC_CTRL = 3'd2;
  localparam logic [ClassW-1:0] MC_SKIP = 3'd3;

  localparam logic [2:0] ERR_STRAY       = 3'd0;
  localparam logic [2:0] ERR_BAD_TWO     = 3'd1;
  localparam logic [2:0] ERR_BAD_THREE   = 3'd2;
  localparam logic [2:0] ERR_STATUS_ONLY = 3'd3;
  localparam logic [2:0] ERR_SYSEX       = 3'd4;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [7:0] ST_SYSEX_START = 8'hf0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hf7;
  localparam logic [7:0] ST_F1          = 8'hf1;
  localparam logic [7:0] ST_F2          = 8'hf2;
  localparam logic [7:0] ST_F3          = 8'hf3;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'ha;
  localparam logic [3:0] HI_CTRL      = 4'hb;
  localparam logic [3:0] HI_PROGRAM   = 4'hc;
  localparam logic [3:0] HI_CHAN_AT   = 4'hd;
  localparam logic [3:0] HI_PITCH     = 4'he;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ClassW-1:0] message_class;
    logic [3:0]        channel_held;
    logic [7:0]        first_data;
  } parser_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_read;
    logic [4:0] device;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] device_out;
    logic [3:0] channel;
    logic [7:0] slot;
    logic [6:0] level;
    logic [2:0] error_code;
  } out_beat_t;

endpackage

// ===== hdl/mmp_if.sv =====
// byte and result channel interfaces
interface mmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_read;
  logic [4:0] device;

  modport source (output valid, output data_byte, output last_in_read, output device,
                  input ready);
  modport sink (input valid, input data_byte, input last_in_read, input device,
                output ready);
endinterface

interface mmp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] device_out;
  logic [3:0] channel;
  logic [7:0] slot;
  logic [6:0] level;
  logic [2:0] error_code;

  modport source (output valid, output kind, output device_out, output channel,
                  output slot, output level, output error_code, input ready);
  modport sink (input valid, input kind, input device_out, input channel,
                input slot, input level, input error_code, output ready);
endinterface

// ===== hdl/mmp_decode.sv =====
// per-byte parse step: next state and optional result
module mmp_decode (
  input  mmp_pkg::parser_state_t state_i,
  input  mmp_pkg::in_beat_t      beat_i,
  output mmp_pkg::parser_state_t state_o,
  output logic                   res_valid_o,
  output mmp_pkg::out_beat_t     res_o
);
  import mmp_pkg::*;

  logic [7:0] b;
  logic [3:0] hi;
  logic       last;
  logic       is_three;
  logic       is_two;
  logic       err_hit;
  logic [2:0] err_code;
  logic       evt_hit;

  assign b    = beat_i.data_byte;
  assign hi   = b[7:4];
  assign last = beat_i.last_in_read;

  assign is_three = (hi == HI_NOTE_OFF) || (hi == HI_NOTE_ON) || (hi == HI_CTRL) ||
                    (hi == HI_POLY_AT) || (hi == HI_PITCH) || (b == ST_F2);
  assign is_two   = (hi == HI_PROGRAM) || (hi == HI_CHAN_AT) || (b == ST_F1) || (b == ST_F3);

  always_comb begin
    state_o  = state_i;
    err_hit  = 1'b0;
    err_code = ERR_STRAY;
    evt_hit  = 1'b0;
    case (state_i.phase)
      PH_IDLE: begin
        if (!b[7]) begin
          err_hit  = 1'b1;
          err_code = ERR_STRAY;
        end else begin
          state_o.channel_held = b[3:0];
          if (is_three) begin
            if (hi == HI_NOTE_OFF) begin
              state_o.message_class = MC_OFF;
            end else if (hi == HI_NOTE_ON) begin
              state_o.message_class = MC_ON;
            end else if (hi == HI_CTRL) begin
              state_o.message_class = MC_CTRL;
            end else begin
              state_o.message_class = MC_SKIP;
            end
            if (last) begin
              err_hit  = 1'b1;
              err_code = ERR_STATUS_ONLY;
            end else begin
              state_o.phase = PH_D1OF3;
            end
          end else if (is_two) begin
            if (last) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_TWO;
            end else begin
              state_o.phase = PH_D1OF2;
            end
          end else if (b == ST_SYSEX_START) begin
            if (last) begin
              err_hit  = 1'b1;
              err_code = ERR_SYSEX;
            end else begin
              state_o.phase = PH_SYSEX;
            end
          end
        end
      end
      PH_D1OF3: begin
        state_o.first_data = b;
        if (last) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_THREE;
        end else begin
          state_o.phase = PH_D2OF3;
        end
      end
      PH_D2OF3: begin
        if (b[7]) begin
          err_hit  = 1'b1;
          err_code = ERR_STATUS_ONLY;
        end else if (state_i.first_data[7]) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_THREE;
        end else begin
          evt_hit       = (state_i.message_class == MC_OFF) ||
                          (state_i.message_class == MC_ON) ||
                          (state_i.message_class == MC_CTRL);
          state_o.phase = PH_IDLE;
        end
      end
      PH_D1OF2: begin
        if (b[7]) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_TWO;
        end else begin
          state_o.phase = PH_IDLE;
        end
      end
      PH_SYSEX: begin
        if (b == ST_SYSEX_END) begin
          state_o.phase = PH_IDLE;
        end else if (last) begin
          err_hit  = 1'b1;
          err_code = ERR_SYSEX;
        end
      end
      default: begin
      end
    endcase

    if (err_hit && !last) begin
      state_o.phase = PH_DROP;
    end else if (last) begin
      state_o.phase = PH_IDLE;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.device_out = beat_i.device;
    res_valid_o      = err_hit || evt_hit;
    if (err_hit) begin
      res_o.kind       = KIND_ERROR;
      res_o.error_code = err_code;
    end else begin
      res_o.kind    = KIND_EVENT;
      res_o.channel = state_i.channel_held;
      if (state_i.message_class == MC_CTRL) begin
        res_o.slot = {1'b1, state_i.first_data[6:0]};
      end else begin
        res_o.slot = state_i.first_data;
      end
      if (state_i.message_class == MC_OFF) begin
        res_o.level = 7'd0;
      end else begin
        res_o.level = b[6:0];
      end
    end
  end

endmodule

// ===== hdl/midi_message_parser.sv =====
// midi message parser top level: parse state, result register and skid stage
// Takes one raw MIDI byte per beat and returns at most one result per byte: a key
// or controller value event, or an error. A byte is accepted every cycle while
// the skid stage is empty, and its result is registered. The output register is
// backed by a one-entry skid stage, so input beats keep flowing while a result
// waits; input ready drops only when both hold results. Parsing restarts at
// every byte flagged as the last of a read; no running status is kept.
module midi_message_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmp_in_if.sink    in_i,
  mmp_out_if.source out_o
);
  import mmp_pkg::*;

  parser_state_t state_q, state_d;
  in_beat_t      beat;
  out_beat_t     res;
  logic          res_valid;
  logic          in_acc;
  logic          push;
  logic          pop;

  out_beat_t main_q, main_d;
  out_beat_t skid_q, skid_d;
  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;

  assign beat.data_byte    = in_i.data_byte;
  assign beat.last_in_read = in_i.last_in_read;
  assign beat.device       = in_i.device;

  mmp_decode u_decode (
    .state_i     (state_q),
    .beat_i      (beat),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign push       = in_acc && res_valid;
  assign pop        = main_valid_q && out_o.ready;

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_d       = res;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_IDLE;
      state_q.message_class <= MC_OFF;
      state_q.channel_held  <= 4'd0;
      state_q.first_data    <= 8'd0;
      main_valid_q          <= 1'b0;
      skid_valid_q          <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid      = main_valid_q;
  assign out_o.kind       = main_q.kind;
  assign out_o.device_out = main_q.device_out;
  assign out_o.channel    = main_q.channel;
  assign out_o.slot       = main_q.slot;
  assign out_o.level      = main_q.level;
  assign out_o.error_code = main_q.error_code;

endmodule
